>>> src/lmtw_pkg.sv
// Shared types, constants and step program for the two-wire display writer.
package lmtw_pkg;

    localparam int COL_W     = 4;
    localparam int NUM_STEPS = 9;
    localparam int PHASE_W   = 4;

    localparam logic CMD_COLUMN = 1'b0;
    localparam logic CMD_BRIGHT = 1'b1;

    localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
    localparam logic [7:0] BYTE_ADDR_CMD = 8'hC0;
    localparam logic [7:0] BYTE_PAD      = 8'h00;
    localparam logic [7:0] BRIGHT_MAX    = 8'd7;

    localparam logic [7:0] BRIGHT_TABLE [8] = '{
        8'hA0, 8'hA4, 8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF
    };

    // Step positions in the fixed program
    localparam int S_START0 = 0;
    localparam int S_DCMD   = 1;
    localparam int S_STOP0  = 2;
    localparam int S_START1 = 3;
    localparam int S_ADDR   = 4;
    localparam int S_VALUE  = 5;
    localparam int S_PAD0   = 6;
    localparam int S_PAD1   = 7;
    localparam int S_STOP1  = 8;

    typedef logic [NUM_STEPS-1:0] step_mask_t;
    typedef logic [$clog2(NUM_STEPS)-1:0] step_idx_t;

    localparam step_mask_t MASK_PRE    = step_mask_t'(9'b0_0001_1111);
    localparam step_mask_t MASK_VALUE  = step_mask_t'(9'b0_0010_0000);
    localparam step_mask_t MASK_POST   = step_mask_t'(9'b1_1100_0000);
    localparam step_mask_t MASK_BRIGHT = step_mask_t'(9'b1_0010_1000);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef struct packed {
        step_mask_t  mask;
        logic [7:0]  value;
    } desc_t;

    typedef struct packed {
        logic push;
    } fifo_wr_t;

    typedef struct packed {
        logic pop;
    } fifo_rd_t;

    function automatic op_t step_op(input step_idx_t idx);
        op_t op;
        op = OP_BYTE;
        unique case (idx)
            step_idx_t'(S_START0), step_idx_t'(S_START1): op = OP_START;
            step_idx_t'(S_STOP0), step_idx_t'(S_STOP1):   op = OP_STOP;
            default:                                      op = OP_BYTE;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] step_byte(input step_idx_t idx, input logic [7:0] value);
        logic [7:0] b;
        b = value;
        unique case (idx)
            step_idx_t'(S_DCMD): b = BYTE_DATA_CMD;
            step_idx_t'(S_ADDR): b = BYTE_ADDR_CMD;
            step_idx_t'(S_PAD0), step_idx_t'(S_PAD1): b = BYTE_PAD;
            default: b = value;
        endcase
        return b;
    endfunction

endpackage

>>> src/lmtw_in_if.sv
// Input item channel: command and value.
interface lmtw_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

>>> src/lmtw_out_if.sv
// Output phase channel: clock and data pin levels.
interface lmtw_out_if;
    logic valid;
    logic ready;
    logic clk_level;
    logic data_level;
    logic last_phase;

    modport source (output valid, output clk_level, output data_level, output last_phase,
                    input ready);
    modport sink   (input valid, input clk_level, input data_level, input last_phase,
                    output ready);
endinterface

>>> src/lmtw_front.sv
// Front end: accept items, track the column and build step descriptors.
module lmtw_front #(
    parameter int COLUMNS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lmtw_in_if.sink              item,
    output lmtw_pkg::fifo_wr_t   wr,
    input  logic                 wr_full,
    output lmtw_pkg::desc_t      desc
);

    localparam logic [lmtw_pkg::COL_W-1:0] LAST_COL = lmtw_pkg::COL_W'(COLUMNS - 1);

    logic [lmtw_pkg::COL_W-1:0] col_reg;
    logic [lmtw_pkg::COL_W-1:0] col_next;
    logic                       accept;
    logic                       is_last;
    logic [2:0]                 level;

    assign item.ready = !wr_full;
    assign accept     = item.valid && item.ready;
    assign is_last    = (col_reg >= LAST_COL);
    assign level      = (item.value > lmtw_pkg::BRIGHT_MAX) ? 3'd7 : item.value[2:0];

    always_comb
    begin
        col_next = col_reg;
        if (accept && item.cmd == lmtw_pkg::CMD_COLUMN)
        begin
            col_next = is_last ? '0 : col_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (item.cmd == lmtw_pkg::CMD_BRIGHT)
        begin
            desc.mask  = lmtw_pkg::MASK_BRIGHT;
            desc.value = lmtw_pkg::BRIGHT_TABLE[level];
        end
        else
        begin
            desc.mask  = lmtw_pkg::MASK_VALUE
                       | ((col_reg == '0) ? lmtw_pkg::MASK_PRE : '0)
                       | (is_last ? lmtw_pkg::MASK_POST : '0);
            desc.value = item.value;
        end
    end

    assign wr.push = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

endmodule

>>> src/lmtw_fifo.sv
// Two-entry descriptor queue between front and back ends.
module lmtw_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  lmtw_pkg::fifo_wr_t wr,
    input  lmtw_pkg::desc_t    wr_desc,
    output logic               full,
    input  lmtw_pkg::fifo_rd_t rd,
    output logic               empty,
    output lmtw_pkg::desc_t    rd_desc
);

    lmtw_pkg::desc_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = wr.push && !full;
    assign do_pop  = rd.pop && !empty;
    assign rd_desc = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

>>> src/lmtw_back.sv
// Back end: walk the step program and emit one pin phase per transfer.
module lmtw_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  lmtw_pkg::desc_t    desc,
    output lmtw_pkg::fifo_rd_t rd,
    lmtw_out_if.source         phase
);

    lmtw_pkg::step_mask_t              mask_reg;
    lmtw_pkg::step_mask_t              mask_next;
    logic [7:0]                        value_reg;
    logic [lmtw_pkg::PHASE_W-1:0]      ph_reg;
    logic [lmtw_pkg::PHASE_W-1:0]      ph_next;
    logic                              out_valid_reg;
    logic                              out_clk_reg;
    logic                              out_data_reg;
    logic                              out_last_reg;

    lmtw_pkg::step_mask_t              cur_onehot;
    lmtw_pkg::step_idx_t               cur_idx;
    lmtw_pkg::op_t                     cur_op;
    logic [7:0]                        cur_byte;
    logic                              busy;
    logic                              advance;
    logic                              step_end;
    logic                              final_phase;
    logic                              load;
    logic                              ph_clk;
    logic                              ph_data;

    assign busy       = (mask_reg != '0);
    assign cur_onehot = mask_reg & (~mask_reg + 1'b1);

    always_comb
    begin
        cur_idx = '0;
        for (int i = lmtw_pkg::NUM_STEPS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                cur_idx = lmtw_pkg::step_idx_t'(i);
            end
        end
    end

    assign cur_op   = lmtw_pkg::step_op(cur_idx);
    assign cur_byte = lmtw_pkg::step_byte(cur_idx, value_reg);

    always_comb
    begin
        ph_clk   = 1'b0;
        ph_data  = 1'b0;
        step_end = 1'b0;
        unique case (cur_op)
            lmtw_pkg::OP_START:
            begin
                ph_clk   = 1'b1;
                ph_data  = (ph_reg == 4'd0);
                step_end = (ph_reg == 4'd1);
            end
            lmtw_pkg::OP_STOP:
            begin
                ph_clk   = (ph_reg != 4'd0);
                ph_data  = (ph_reg == 4'd2);
                step_end = (ph_reg == 4'd2);
            end
            lmtw_pkg::OP_BYTE:
            begin
                ph_clk   = ph_reg[0];
                ph_data  = cur_byte[ph_reg[3:1]];
                step_end = (ph_reg == 4'd15);
            end
            default:
            begin
                ph_clk   = 1'b0;
                ph_data  = 1'b0;
                step_end = 1'b0;
            end
        endcase
    end

    assign advance     = busy && (!out_valid_reg || phase.ready);
    assign final_phase = step_end && ((mask_reg & ~cur_onehot) == '0);
    assign load        = (!busy || (advance && final_phase)) && !empty;
    assign rd.pop      = load;

    always_comb
    begin
        mask_next = mask_reg;
        ph_next   = ph_reg;
        if (advance)
        begin
            if (step_end)
            begin
                mask_next = mask_reg & ~cur_onehot;
                ph_next   = '0;
            end
            else
            begin
                ph_next = ph_reg + 1'b1;
            end
        end
        if (load)
        begin
            mask_next = desc.mask;
            ph_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            ph_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            ph_reg   <= ph_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (phase.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= desc.value;
        end
        if (advance)
        begin
            out_clk_reg  <= ph_clk;
            out_data_reg <= ph_data;
            out_last_reg <= final_phase;
        end
    end

    assign phase.valid      = out_valid_reg;
    assign phase.clk_level  = out_clk_reg;
    assign phase.data_level = out_data_reg;
    assign phase.last_phase = out_last_reg;

endmodule

>>> src/led_matrix_two_wire_writer.sv
// Top level of the two-wire LED display writer.
//
//  channel  | dir | payload                              | transfer when
//  ---------+-----+--------------------------------------+------------------
//  item     | in  | cmd (1), value (8)                   | valid && ready
//  phase    | out | clk_level, data_level, last_phase    | valid && ready
//
// One pin phase per cycle leaves the back-end sequencer unless phase stalls;
// a column is one byte, with set-up before the first and pads after the last.
// A two-entry queue lets items be taken while earlier ones are still emitted.
// Reset clears the column counter, queue and sequencer; no clearing pass.
// A stall on phase holds the output register and the sequencer in place.
module led_matrix_two_wire_writer #(
    parameter int COLUMNS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    lmtw_in_if.sink     item,
    lmtw_out_if.source  phase
);

    lmtw_pkg::fifo_wr_t wr;
    lmtw_pkg::fifo_rd_t rd;
    lmtw_pkg::desc_t    wr_desc;
    lmtw_pkg::desc_t    rd_desc;
    logic               full;
    logic               empty;

    lmtw_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .wr      (wr),
        .wr_full (full),
        .desc    (wr_desc)
    );

    lmtw_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_desc (wr_desc),
        .full    (full),
        .rd      (rd),
        .empty   (empty),
        .rd_desc (rd_desc)
    );

    lmtw_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .desc  (rd_desc),
        .rd    (rd),
        .phase (phase)
    );

endmodule

>>> src/lmtw_checker.sv
// Port-level checks for the two-wire display writer, bound to the top level.
module lmtw_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic out_clk,
    input logic out_data,
    input logic out_last
);

    logic out_xfer;

    assign out_xfer = out_valid && out_ready;

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("phase valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_clk) && $stable(out_data) && $stable(out_last))
        else $error("phase payload changed while stalled");

    a_last_clk_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && out_last |-> out_clk)
        else $error("final phase of an item left clock low");

    a_no_double_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !out_clk |=> !(out_xfer && !out_clk))
        else $error("two consecutive clock-low phases");

endmodule

bind led_matrix_two_wire_writer lmtw_checker u_lmtw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (phase.valid),
    .out_ready (phase.ready),
    .out_clk   (phase.clk_level),
    .out_data  (phase.data_level),
    .out_last  (phase.last_phase)
);

>>> bench/lmtw_phase_checker.sv
// Checker for the two-wire display writer: predicts pin phases from input transfers and compares.
module lmtw_phase_checker #(
    parameter int COLUMNS = 14
) (
    input  logic clk,
    input  logic rst_n,
    lmtw_in_if   item,
    lmtw_out_if  phase,
    output int   fail_count,
    output int   phases_outstanding
);

    typedef struct packed {
        logic clk_level;
        logic data_level;
        logic last_phase;
    } pin_phase_t;

    localparam logic [7:0] LEVEL_CODE [8] = '{
        8'hA0, 8'hA4, 8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF
    };
    localparam logic [7:0] TOP_LEVEL     = 8'd7;
    localparam logic [7:0] SET_DATA_MODE = 8'h40;
    localparam logic [7:0] SET_ADDRESS   = 8'hC0;
    localparam logic [7:0] PAD_BYTE      = 8'h00;

    pin_phase_t                 expected_phases [$];
    logic [lmtw_pkg::COL_W-1:0] next_column;
    int                         errors;
    pin_phase_t                 got;
    pin_phase_t                 want;

    function automatic void push_phase(input logic clk_lvl, input logic data_lvl);
        pin_phase_t p;
        p.clk_level  = clk_lvl;
        p.data_level = data_lvl;
        p.last_phase = 1'b0;
        expected_phases.push_back(p);
    endfunction

    function automatic void push_start();
        push_phase(1'b1, 1'b1);
        push_phase(1'b1, 1'b0);
    endfunction

    function automatic void push_stop();
        push_phase(1'b0, 1'b0);
        push_phase(1'b1, 1'b0);
        push_phase(1'b1, 1'b1);
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        for (int i = 0; i < 8; i++)
        begin
            push_phase(1'b0, b[i]);
            push_phase(1'b1, b[i]);
        end
    endfunction

    function automatic void predict_item(input logic cmd, input logic [7:0] value);
        logic [7:0] level;
        int         n;
        if (cmd == lmtw_pkg::CMD_BRIGHT)
        begin
            level = (value > TOP_LEVEL) ? TOP_LEVEL : value;
            push_start();
            push_byte(LEVEL_CODE[level[2:0]]);
            push_stop();
        end
        else
        begin
            if (next_column == '0)
            begin
                push_start();
                push_byte(SET_DATA_MODE);
                push_stop();
                push_start();
                push_byte(SET_ADDRESS);
            end
            push_byte(value);
            if (int'(next_column) >= COLUMNS - 1)
            begin
                push_byte(PAD_BYTE);
                push_byte(PAD_BYTE);
                push_stop();
                next_column = '0;
            end
            else
            begin
                next_column = next_column + 1'b1;
            end
        end
        n = expected_phases.size();
        expected_phases[n-1].last_phase = 1'b1;
    endfunction

    function automatic void check_field(input string field, input logic exp_v, input logic act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %0b got %0b", $time, field, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_phases.delete();
            next_column = '0;
            errors = 0;
            fail_count <= 0;
            phases_outstanding <= 0;
        end
        else
        begin
            if (item.valid && item.ready)
                predict_item(item.cmd, item.value);
            if (phase.valid && phase.ready)
            begin
                got = {phase.clk_level, phase.data_level, phase.last_phase};
                if (expected_phases.size() == 0)
                begin
                    errors++;
                    $display("%0t: phase expected none got clk %0b data %0b last %0b",
                             $time, got.clk_level, got.data_level, got.last_phase);
                end
                else
                begin
                    want = expected_phases.pop_front();
                    check_field("clk_level", want.clk_level, got.clk_level);
                    check_field("data_level", want.data_level, got.data_level);
                    check_field("last_phase", want.last_phase, got.last_phase);
                end
            end
            fail_count <= errors;
            phases_outstanding <= expected_phases.size();
        end
    end

endmodule

>>> bench/testbench.sv
// Top of the two-wire display writer bench: clock, reset, stimulus, stalls and verdict.
module testbench;

    localparam int COLUMNS        = 14;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] DIRECTED_LEVELS [10] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd255
    };

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic long_hold;
    int   quiet_cycles;
    int   fail_count;
    int   phases_outstanding;

    lmtw_in_if  item ();
    lmtw_out_if phase ();

    led_matrix_two_wire_writer #(
        .COLUMNS (COLUMNS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .phase (phase)
    );

    lmtw_phase_checker #(
        .COLUMNS (COLUMNS)
    ) phase_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .item               (item),
        .phase              (phase),
        .fail_count         (fail_count),
        .phases_outstanding (phases_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send_item(input logic cmd, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.cmd   <= cmd;
        item.value <= value;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    task automatic send_random_items(input int count);
        logic [7:0] level;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 20)
            begin
                level = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(9));
                send_item(lmtw_pkg::CMD_BRIGHT, level);
            end
            else
            begin
                send_item(lmtw_pkg::CMD_COLUMN, 8'($urandom_range(255)));
            end
        end
    endtask

    // Receiver: random stalls, or one long hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                phase.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                phase.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item.valid && item.ready) || (phase.valid && phase.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] col_value;
        rst_n          = 1'b0;
        item.valid     = 1'b0;
        item.cmd       = lmtw_pkg::CMD_COLUMN;
        item.value     = '0;
        phase.ready    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold      = 1'b0;
        quiet_cycles   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one full frame, brightness levels interleaved in the first ten columns
        for (int col = 0; col < COLUMNS; col++)
        begin
            case (col)
                0:       col_value = 8'h00;
                1:       col_value = 8'hFF;
                default: col_value = (col < 10) ? 8'(1 << (col - 2)) : 8'($urandom_range(255));
            endcase
            send_item(lmtw_pkg::CMD_COLUMN, col_value);
            if (col < 10)
                send_item(lmtw_pkg::CMD_BRIGHT, DIRECTED_LEVELS[col]);
        end

        send_random_items(70);

        send_idle_pct  = 51;
        recv_stall_pct = 0;
        send_random_items(70);

        send_idle_pct  = 0;
        recv_stall_pct = 51;
        send_random_items(70);

        send_idle_pct  = 28;
        recv_stall_pct = 28;
        send_random_items(70);

        // hold the output off while items keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold      = 1'b1;
        send_random_items(50);

        item.valid <= 1'b0;
        @(posedge clk);
        while (phases_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && phases_outstanding == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/lmtw_pkg.sv
src/lmtw_in_if.sv
src/lmtw_out_if.sv
src/lmtw_front.sv
src/lmtw_fifo.sv
src/lmtw_back.sv
src/led_matrix_two_wire_writer.sv
src/lmtw_checker.sv
bench/lmtw_phase_checker.sv
bench/testbench.sv
